### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the pedal shaper checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define PPS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Checked on every edge, reset included.
`define PPS_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

### rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Constants, register indexes and the exp factor table of the pedal shaper.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int ADC_BITS_DEF  = 12;
   localparam int FRAC_BITS_DEF = 16;
   localparam int Q16_BITS      = 16;   // width of Q0.16 registers and result
   localparam int LOG_BITS      = 20;   // fraction bits of the log2 value
   localparam int EXP_BITS      = 16;   // exponent register width (Q4.12)
   localparam int EXP_FRAC      = 12;
   localparam int Q_BITS        = 30;   // internal Q1.30 format
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] REG_CAL_LOW        = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_CAL_HIGH       = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_REVERSE_MODE   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_DEADZONE       = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_CURVE_EXPONENT = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_REMAP_FLOOR    = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_FILTER_ALPHA   = 3'd6;

   typedef logic [Q_BITS:0] tfac_arr_type [LOG_BITS];

   function automatic logic [63:0] isqrt64(logic [63:0] n);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bt;
      rem = n;
      res = '0;
      bt  = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bt) begin
            rem = rem - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // Entry i is 2^(-2^-(i+1)) in Q1.30, each the truncated root of the last.
   function automatic tfac_arr_type build_tfac();
      tfac_arr_type arr;
      logic [63:0]  t;
      t = 64'd1 << (Q_BITS - 1);
      for (int i = 0; i < LOG_BITS; i++) begin
         t = isqrt64(t << Q_BITS);
         arr[i] = t[Q_BITS:0];
      end
      return arr;
   endfunction

   localparam tfac_arr_type TFAC = build_tfac();

endpackage

### rtl/core/pps_chan_if.sv
// ----------------------------------------------------------------------------
// Pedal shaper channels
// Valid/ready channels for ADC samples in and shaped fractions out.
// ----------------------------------------------------------------------------
interface pps_req_if #(
   parameter int ADC_BITS = pps_pkg::ADC_BITS_DEF
);
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface pps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pps_pkg::Q16_BITS-1:0]  pedal_fraction;
   logic                          status;

   modport source (output valid, output pedal_fraction, output status, input ready);
   modport sink   (input valid, input pedal_fraction, input status, output ready);
endinterface

### rtl/core/pedal_position_shaper_unit.sv
// ----------------------------------------------------------------------------
// pedal_position_shaper_unit
// Normalizes, curves, squares and low-pass filters one pedal ADC sample.
// ----------------------------------------------------------------------------
//  channel   dir  transfer when         payload
//  req_chan  in   valid & ready         adc_sample
//  rsp_chan  out  valid & ready         pedal_fraction, status
//  csr_*     in   csr_wr_en             csr_index, csr_wdata
//
//  One sample at a time; req_chan.ready is high only while idle.
//  Zero span goes straight to the result; otherwise a restoring divide runs
//  (skipped when the quotient is 0 or 1), then, when the power curve runs,
//  k normalize shifts (k <= 12 at ADC_BITS 12), a log2 loop and an exp loop.
//  The log/exp loops and the later steps share one 32x32 multiplier.
//  The result holds on rsp_chan until taken; reset is synchronous, active high.
// ----------------------------------------------------------------------------
module pedal_position_shaper_unit #(
   parameter int ADC_BITS  = pps_pkg::ADC_BITS_DEF,
   parameter int FRAC_BITS = pps_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   pps_req_if.sink                           req_chan,
   pps_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [pps_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [pps_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import pps_pkg::*;

   localparam int FW      = FRAC_BITS + 1;
   localparam int ACCW    = 2 * FW;
   localparam int KW      = $clog2(FRAC_BITS + 1);
   localparam int LGW     = KW + LOG_BITS;
   localparam int IPW     = LGW + EXP_BITS - EXP_FRAC - LOG_BITS;
   localparam int CNT_MAX = (FRAC_BITS > LOG_BITS) ? FRAC_BITS : LOG_BITS;
   localparam int CNTW    = $clog2(CNT_MAX + 1);
   localparam int IDXW    = $clog2(LOG_BITS);
   localparam longint ONE_I = longint'(1) << FRAC_BITS;
   localparam logic [FW-1:0] ONE = FW'(ONE_I);
   localparam logic [FW-1:0] C08 = FW'((8 * ONE_I + 50) / 100);
   localparam logic [FW-1:0] C05 = FW'((5 * ONE_I + 50) / 100);
   localparam logic [Q_BITS:0] Q30 = (Q_BITS + 1)'(1) << Q_BITS;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_DIV    = 13'b0000000000010,
      ST_CHK    = 13'b0000000000100,
      ST_NORM   = 13'b0000000001000,
      ST_LOG    = 13'b0000000010000,
      ST_LGMUL  = 13'b0000000100000,
      ST_EXP    = 13'b0000001000000,
      ST_PSHIFT = 13'b0000010000000,
      ST_REMAP  = 13'b0000100000000,
      ST_SQUARE = 13'b0001000000000,
      ST_BLEND1 = 13'b0010000000000,
      ST_BLEND2 = 13'b0100000000000,
      ST_DONE   = 13'b1000000000000
   } state_type;

   function automatic logic [FW-1:0] from_q16(logic [Q16_BITS-1:0] v);
      logic [39:0] t;
      t = {v, 24'd0} >> (40 - FRAC_BITS);
      return t[FW-1:0];
   endfunction

   function automatic logic [Q16_BITS-1:0] to_q16(logic [FW-1:0] v);
      logic [FW+23:0] t;
      t = (FW + 24)'(v) << 24;
      t = t >> (FRAC_BITS + 8);
      return (|t[FW+23:Q16_BITS]) ? {Q16_BITS{1'b1}} : t[Q16_BITS-1:0];
   endfunction

   // configuration
   logic [ADC_BITS-1:0] cal_low_ff, cal_high_ff;
   logic                reverse_mode_ff;
   logic [15:0]         deadzone_ff, curve_exponent_ff, remap_floor_ff, filter_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_low_ff        <= '0;
         cal_high_ff       <= '1;
         reverse_mode_ff   <= 1'b0;
         deadzone_ff       <= '0;
         curve_exponent_ff <= 16'd4096;
         remap_floor_ff    <= '0;
         filter_alpha_ff   <= 16'hFFFF;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_CAL_LOW:        cal_low_ff        <= csr_wdata[ADC_BITS-1:0];
            REG_CAL_HIGH:       cal_high_ff       <= csr_wdata[ADC_BITS-1:0];
            REG_REVERSE_MODE:   reverse_mode_ff   <= csr_wdata[0];
            REG_DEADZONE:       deadzone_ff       <= csr_wdata;
            REG_CURVE_EXPONENT: curve_exponent_ff <= csr_wdata;
            REG_REMAP_FLOOR:    remap_floor_ff    <= csr_wdata;
            REG_FILTER_ALPHA:   filter_alpha_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   state_type           state_ff, state_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic [ADC_BITS-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [FW-1:0]       x_ff, x_in, pw_ff, pw_in, y_ff, y_in, s_ff, s_in;
   logic [FW-1:0]       prev_ff, prev_in;
   logic [Q_BITS:0]     m_ff, m_in, r_ff, r_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [LOG_BITS-1:0] f_ff, f_in, fp_ff, fp_in;
   logic [IPW-1:0]      ip_ff, ip_in;
   logic [ACCW-1:0]     acc_ff, acc_in;
   logic [Q16_BITS-1:0] frac_ff, frac_in;
   logic                status_ff, status_in;

   // sample normalization operands
   logic [ADC_BITS-1:0] adc_s, num, den;
   logic                nneg, dneg;
   assign adc_s = req_chan.adc_sample;
   assign nneg  = adc_s < cal_low_ff;
   assign num   = nneg ? cal_low_ff - adc_s : adc_s - cal_low_ff;
   assign dneg  = cal_high_ff < cal_low_ff;
   assign den   = dneg ? cal_low_ff - cal_high_ff : cal_high_ff - cal_low_ff;

   logic [FW-1:0] fl, al, dz, yeff, sq, blend;
   assign fl   = from_q16(remap_floor_ff);
   assign al   = from_q16(filter_alpha_ff);
   assign dz   = from_q16(deadzone_ff);
   assign yeff = reverse_mode_ff ? ONE - y_ff : y_ff;

   logic [ADC_BITS:0]  rem2;
   logic [LGW-1:0]     lg;
   logic [IPW:0]       sh;
   logic [Q_BITS:0]    pw_shift;
   logic [ACCW-1:0]    blend_sum;
   logic [31:0]        sq_t;
   assign rem2     = {rem_ff, 1'b0};
   assign lg       = {k_ff, {LOG_BITS{1'b0}}} - LGW'(f_ff);
   assign sh       = (IPW + 1)'(Q_BITS - FRAC_BITS) + (IPW + 1)'(ip_ff);
   assign pw_shift = r_ff >> sh;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_LOG:    begin mul_a = 32'(m_ff);       mul_b = 32'(m_ff);                 end
         ST_LGMUL:  begin mul_a = 32'(lg);         mul_b = 32'(curve_exponent_ff);    end
         ST_EXP:    begin mul_a = 32'(r_ff);       mul_b = 32'(TFAC[cnt_ff[IDXW-1:0]]); end
         ST_REMAP:  begin mul_a = 32'(ONE - fl);   mul_b = 32'(pw_ff);                end
         ST_SQUARE: begin mul_a = 32'(yeff);       mul_b = 32'(yeff);                 end
         ST_BLEND1: begin mul_a = 32'(al);         mul_b = 32'(s_ff);                 end
         ST_BLEND2: begin mul_a = 32'(ONE - al);   mul_b = 32'(prev_ff);              end
         default: ;
      endcase
   end
   assign mul_p = mul_a * mul_b;

   assign sq_t      = mul_p[Q_BITS +: 32];
   assign sq        = mul_p[FRAC_BITS +: FW];
   assign blend_sum = acc_ff + mul_p[ACCW-1:0];
   assign blend     = blend_sum[FRAC_BITS +: FW];

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      x_in      = x_ff;
      pw_in     = pw_ff;
      y_in      = y_ff;
      s_in      = s_ff;
      prev_in   = prev_ff;
      m_in      = m_ff;
      r_in      = r_ff;
      k_in      = k_ff;
      f_in      = f_ff;
      fp_in     = fp_ff;
      ip_in     = ip_ff;
      acc_in    = acc_ff;
      frac_in   = frac_ff;
      status_in = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               den_in = den;
               rem_in = num;
               x_in   = '0;
               cnt_in = CNTW'(FRAC_BITS);
               priority if (cal_high_ff == cal_low_ff) begin
                  frac_in   = '0;
                  status_in = 1'b1;
                  state_in  = ST_DONE;
               end else if (num == '0 || nneg != dneg) begin
                  state_in = ST_CHK;
               end else if (num >= den) begin
                  x_in     = ONE;
                  state_in = ST_CHK;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem2 >= {1'b0, den_ff}) begin
               rem_in = ADC_BITS'(rem2 - {1'b0, den_ff});
               x_in   = {x_ff[FW-2:0], 1'b1};
            end else begin
               rem_in = rem2[ADC_BITS-1:0];
               x_in   = {x_ff[FW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNTW'(1)) state_in = ST_CHK;
         end
         ST_CHK: begin
            m_in = (Q_BITS + 1)'(x_ff) << (Q_BITS - FRAC_BITS);
            k_in = '0;
            priority if (x_ff < dz) begin
               y_in     = '0;
               state_in = ST_SQUARE;
            end else if (curve_exponent_ff == '0 || x_ff >= ONE) begin
               pw_in    = ONE;
               state_in = ST_REMAP;
            end else if (x_ff == '0) begin
               pw_in    = '0;
               state_in = ST_REMAP;
            end else begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (!m_ff[Q_BITS-0 -: 1] && m_ff < Q30) begin
               m_in = m_ff << 1;
               k_in = k_ff + 1'b1;
            end else begin
               f_in     = '0;
               cnt_in   = CNTW'(LOG_BITS);
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            // one log2 fraction bit per squaring
            if (sq_t[31]) begin
               m_in = sq_t[31:1];
               f_in = {f_ff[LOG_BITS-2:0], 1'b1};
            end else begin
               m_in = sq_t[Q_BITS:0];
               f_in = {f_ff[LOG_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNTW'(1)) state_in = ST_LGMUL;
         end
         ST_LGMUL: begin
            fp_in    = mul_p[EXP_FRAC +: LOG_BITS];
            ip_in    = mul_p[EXP_FRAC + LOG_BITS +: IPW];
            r_in     = Q30;
            cnt_in   = '0;
            state_in = ST_EXP;
         end
         ST_EXP: begin
            if (fp_ff[LOG_BITS-1]) r_in = mul_p[Q_BITS +: Q_BITS + 1];
            fp_in  = fp_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(LOG_BITS - 1)) state_in = ST_PSHIFT;
         end
         ST_PSHIFT: begin
            pw_in    = pw_shift[FW-1:0];
            state_in = ST_REMAP;
         end
         ST_REMAP: begin
            y_in     = fl + sq;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            s_in     = (sq > C08) ? sq - C08 : '0;
            state_in = ST_BLEND1;
         end
         ST_BLEND1: begin
            acc_in   = mul_p[ACCW-1:0];
            state_in = ST_BLEND2;
         end
         ST_BLEND2: begin
            frac_in   = (blend <= C05) ? '0 : to_q16(blend);
            status_in = 1'b0;
            prev_in   = s_ff;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_chan.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         prev_ff  <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      x_ff      <= x_in;
      pw_ff     <= pw_in;
      y_ff      <= y_in;
      s_ff      <= s_in;
      m_ff      <= m_in;
      r_ff      <= r_in;
      k_ff      <= k_in;
      f_ff      <= f_in;
      fp_ff     <= fp_in;
      ip_ff     <= ip_in;
      acc_ff    <= acc_in;
      frac_ff   <= frac_in;
      status_ff <= status_in;
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = (state_ff == ST_DONE);
   assign rsp_chan.pedal_fraction = frac_ff;
   assign rsp_chan.status         = status_ff;

endmodule

### rtl/core/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks of the pedal shaper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pps_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [pps_pkg::Q16_BITS-1:0] rsp_fraction,
   input logic                         rsp_status
);
   import pps_pkg::*;

   // a pending result stays offered
   `PPS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   // no new sample while a result waits
   `PPS_ASSERT(a_busy_out, clock, reset, rsp_valid |-> !req_ready)
   // a transfer in closes the input side next cycle
   `PPS_ASSERT(a_busy_in, clock, reset, req_valid && req_ready |=> !req_ready)
   // calibration error carries a zero fraction
   `PPS_ASSERT(a_err_zero, clock, reset,
      rsp_valid && rsp_status |-> rsp_fraction == '0)
   // nothing offered right after reset
   `PPS_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid)

endmodule

bind pedal_position_shaper_unit pps_checker u_pps_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_fraction (rsp_chan.pedal_fraction),
   .rsp_status   (rsp_chan.status)
);

### verif/tb_pedal_position_shaper_unit.sv
// ----------------------------------------------------------------------------
// tb_pedal_position_shaper_unit
// Drives ADC samples through the pedal shaper under several calibration and
// curve settings and checks each shaped fraction against a local predictor.
// ----------------------------------------------------------------------------
module tb_pedal_position_shaper_unit;
   import pps_pkg::*;

   localparam int ONE   = 1 << 16;
   localparam int C08   = (8 * ONE + 50) / 100;
   localparam int C05   = (5 * ONE + 50) / 100;
   localparam int WDOG  = 20000;

   typedef struct packed {
      logic [15:0] pedal_fraction;
      logic        status;
   } shaped_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = REG_CAL_LOW;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   pps_req_if req_chan ();
   pps_rsp_if rsp_chan ();

   pedal_position_shaper_unit uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor copy of the registers and filter state
   logic [11:0] p_cal_low, p_cal_high;
   logic        p_reverse;
   logic [15:0] p_deadzone, p_exponent, p_floor, p_alpha;
   logic [63:0] p_prev_shaped;

   logic [11:0] sample_q[$];
   shaped_type  shaped_q[$];
   int          n_mismatch = 0;
   int          idle_cnt = 0;
   bit          quiet = 0;      // no idling in the last part
   int          req_gap = 0, rsp_gap = 0;

   initial forever #5 clock = ~clock;

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] res, b;
      res = '0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] curve_pow(logic [63:0] x, logic [63:0] e);
      logic [63:0] m, f, lg, p, ip, fp, r, t, sh;
      int k;
      m = x << 14;
      f = '0;
      k = 0;
      if (e == 0 || x >= ONE) return 64'(ONE);
      if (x == 0) return 64'd0;
      while (m < (64'd1 << 30)) begin
         m = m << 1;
         k++;
      end
      for (int i = 0; i < 20; i++) begin
         m = (m * m) >> 30;
         f = f << 1;
         if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            f = f | 64'd1;
         end
      end
      lg = (64'(k) << 20) - f;
      p  = (lg * e) >> 12;
      ip = p >> 20;
      fp = p & ((64'd1 << 20) - 1);
      r  = 64'd1 << 30;
      t  = 64'd1 << 29;
      for (int i = 1; i <= 20; i++) begin
         t = int_sqrt(t << 30);
         if ((fp >> (20 - i)) & 1) r = (r * t) >> 30;
      end
      sh = 14 + ip;
      if (sh >= 63) return 64'd0;
      return r >> sh;
   endfunction

   function automatic shaped_type shape_sample(logic [11:0] adc);
      shaped_type o;
      logic [63:0] num, den, x, y, s, al, bl;
      bit nneg, dneg;
      if (p_cal_high == p_cal_low) begin
         o.pedal_fraction = '0;
         o.status = 1'b1;
         return o;
      end
      nneg = adc < p_cal_low;
      num = nneg ? 64'(p_cal_low - adc) : 64'(adc - p_cal_low);
      dneg = p_cal_high < p_cal_low;
      den = dneg ? 64'(p_cal_low - p_cal_high) : 64'(p_cal_high - p_cal_low);
      if (num == 0 || nneg != dneg) begin
         x = '0;
      end else begin
         x = (num << 16) / den;
         if (x > ONE) x = 64'(ONE);
      end
      if (x < p_deadzone) begin
         y = '0;
      end else begin
         y = 64'(p_floor) + (((ONE - 64'(p_floor)) * curve_pow(x, 64'(p_exponent))) >> 16);
         if (y > ONE) y = 64'(ONE);
      end
      if (p_reverse) y = ONE - y;
      s = (y * y) >> 16;
      s = s > C08 ? s - C08 : 64'd0;
      al = 64'(p_alpha);
      bl = (al * s + (ONE - al) * p_prev_shaped) >> 16;
      if (bl <= C05) bl = '0;
      p_prev_shaped = s;
      o.pedal_fraction = bl > 65535 ? 16'hFFFF : bl[15:0];
      o.status = 1'b0;
      return o;
   endfunction

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_CAL_LOW:        p_cal_low  = val[11:0];
         REG_CAL_HIGH:       p_cal_high = val[11:0];
         REG_REVERSE_MODE:   p_reverse  = val[0];
         REG_DEADZONE:       p_deadzone = val;
         REG_CURVE_EXPONENT: p_exponent = val;
         REG_REMAP_FLOOR:    p_floor    = val;
         REG_FILTER_ALPHA:   p_alpha    = val;
         default: ;
      endcase
   endtask

   task automatic drain();
      wait (sample_q.size() == 0 && shaped_q.size() == 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic setup(logic [11:0] lo, logic [11:0] hi, logic rev, logic [15:0] dz,
                        logic [15:0] ex, logic [15:0] fl, logic [15:0] al);
      drain();
      csr_write(REG_CAL_LOW, {4'd0, lo});
      csr_write(REG_CAL_HIGH, {4'd0, hi});
      csr_write(REG_REVERSE_MODE, {15'd0, rev});
      csr_write(REG_DEADZONE, dz);
      csr_write(REG_CURVE_EXPONENT, ex);
      csr_write(REG_REMAP_FLOOR, fl);
      csr_write(REG_FILTER_ALPHA, al);
   endtask

   task automatic push_random(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            sample_q.push_back($urandom_range(0, 1) ? 12'd0 : 12'hFFF);
         else
            sample_q.push_back(12'($urandom_range(0, 4095)));
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.adc_sample <= '0;
      end else begin
         // a transfer retires the head of the queue before the next pick
         if (req_chan.valid && req_chan.ready) begin
            shaped_q.push_back(shape_sample(req_chan.adc_sample));
            void'(sample_q.pop_front());
         end
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (req_chan.valid && !req_chan.ready) begin
            req_chan.valid <= 1'b1;
         end else if (sample_q.size() > 0) begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
               req_gap <= $urandom_range(1, 15);
               req_chan.valid <= 1'b0;
            end else begin
               req_chan.valid <= 1'b1;
               req_chan.adc_sample <= sample_q[0];
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (shaped_q.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10) $display("unexpected result %h/%b",
                  rsp_chan.pedal_fraction, rsp_chan.status);
            end else if (rsp_chan.pedal_fraction !== shaped_q[0].pedal_fraction ||
                         rsp_chan.status !== shaped_q[0].status) begin
               n_mismatch++;
               if (n_mismatch <= 10) $display("mismatch: expected %h/%b actual %h/%b",
                  shaped_q[0].pedal_fraction, shaped_q[0].status,
                  rsp_chan.pedal_fraction, rsp_chan.status);
               void'(shaped_q.pop_front());
            end else begin
               void'(shaped_q.pop_front());
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_gap <= $urandom_range(1, 15);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // watchdog: cycles without any transfer or CSR write
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          reset || csr_wr_en)
         idle_cnt <= 0;
      else
         idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WDOG) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      p_cal_low = 12'd0; p_cal_high = 12'd4095; p_reverse = 1'b0; p_deadzone = 16'd0;
      p_exponent = 16'd4096; p_floor = 16'd0; p_alpha = 16'hFFFF; p_prev_shaped = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: extremes and midpoint of the sample
      sample_q.push_back(12'd0);
      sample_q.push_back(12'hFFF);
      sample_q.push_back(12'd2048);
      sample_q.push_back(12'd1);
      sample_q.push_back(12'd4094);
      // zero exponent
      setup(12'd100, 12'd4000, 1'b0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
      sample_q.push_back(12'd0);
      sample_q.push_back(12'd100);
      sample_q.push_back(12'd3000);
      // zero span
      setup(12'd500, 12'd500, 1'b0, 16'd0, 16'd4096, 16'd0, 16'hFFFF);
      sample_q.push_back(12'd500);
      sample_q.push_back(12'd4095);
      // reversed calibration, reverse mode, steep exponent (tiny result)
      setup(12'd4000, 12'd200, 1'b1, 16'd1000, 16'hFFFF, 16'd0, 16'd32768);
      sample_q.push_back(12'd4000);
      sample_q.push_back(12'd3990);
      sample_q.push_back(12'd200);
      sample_q.push_back(12'd0);
      sample_q.push_back(12'd2000);
      // deadzone and floor maxed, alpha 0
      setup(12'd0, 12'd4095, 1'b0, 16'hFFFF, 16'd2048, 16'hFFFF, 16'd0);
      sample_q.push_back(12'd4095);
      sample_q.push_back(12'd1000);
      sample_q.push_back(12'd4095);

      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 0)
            setup(12'd0, 12'd4095, 1'b0, 16'd0, 16'd4096, 16'd0, 16'hFFFF);
         else if (ph == 7)
            setup(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), 1'($urandom),
                  16'($urandom_range(0, 8000)), 16'($urandom_range(0, 16'hFFFF)),
                  16'($urandom), 16'($urandom));
         else
            setup(12'($urandom_range(0, 1500)), 12'($urandom_range(2500, 4095)),
                  1'($urandom), 16'($urandom_range(0, 8000)),
                  16'($urandom_range(0, 16384)), 16'($urandom_range(0, 30000)),
                  16'($urandom));
         if (ph == 6) quiet = 1;
         push_random(25);
         // sender holds until every result is back
         wait (sample_q.size() == 0 && shaped_q.size() == 0);
         push_random(25);
      end
      drain();
      if (n_mismatch == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/pps_pkg.sv
rtl/core/pps_chan_if.sv
rtl/core/pedal_position_shaper_unit.sv
rtl/core/pps_checker.sv
verif/tb_pedal_position_shaper_unit.sv
